>>> hdl/video_frame_packetizer_macros.svh
// Assertion helpers for the video frame packetizer.
// Each macro needs clk and arst_n in scope.
`ifndef VIDEO_FRAME_PACKETIZER_MACROS_SVH
`define VIDEO_FRAME_PACKETIZER_MACROS_SVH

`ifndef SYNTHESIS
`define VFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define VFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VFP_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define VFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/vfp_pkg.sv
package vfp_pkg;

	// Packet geometry
	localparam int unsigned PACKET_BYTES = 32768;
	localparam int unsigned HEADER_BYTES = 17;
	localparam int unsigned FILL_W       = 17;
	localparam int unsigned IDX_W        = $clog2(HEADER_BYTES + 1);

	// Byte index at which the back end shows the payload byte
	localparam logic [IDX_W-1:0] PAYLOAD_IDX = IDX_W'(HEADER_BYTES);

	// Start code of every frame header
	localparam logic [31:0] START_CODE = 32'h0000_01FC;

	// Queue between front and back end
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One classified item: a payload byte, optionally led by a header
	typedef struct packed {
		logic        hdr;
		logic [7:0]  data_byte;
		logic        pend;
		logic        fend;
		logic [31:0] fsize;
		logic [31:0] stamp;
		logic [31:0] fcount;
		logic [7:0]  ftype;
	} entry_t;

	// Queue status toward the front end
	typedef struct packed {
		logic full;
		logic valid;
	} queue_stat_t;

	// Pick one header byte, big-endian, index 0 is the first byte sent
	function automatic logic [7:0] hdr_byte(entry_t e, logic [IDX_W-1:0] idx);
		logic [8*HEADER_BYTES-1:0] hdr;
		logic [IDX_W-1:0]          pos;
		logic [7:0]                res;
		hdr = {START_CODE, e.fsize, e.stamp, e.fcount, e.ftype};
		pos = IDX_W'(HEADER_BYTES - 1) - idx;
		res = 8'h00;
		for (int i = 0; i < HEADER_BYTES; i++) begin
			if (pos == IDX_W'(i)) begin
				res = hdr[8*i +: 8];
			end
		end
		return res;
	endfunction

endpackage

>>> hdl/video_frame_packetizer.sv
// Channel   Port group          Payload (low bit first)
// input     s_tvalid/s_tready   tdata: data_byte, frame_size, timestamp_ms; tuser: frame_first
// output    m_tvalid/m_tready   tdata: out_byte; tlast: packet_end; tuser: frame_end, run_last
// config    cfg_we              cfg_wdata: header type byte
//
// A payload item is one output byte; the first item of a frame is led by
// 17 header bytes from the back end's byte sequencer, then the payload.
// The front end takes one item per cycle while the four-entry queue has room.
// arst_n clears frame counter, open-frame state, queue and output valid.
// A stalled m_tready holds the current byte; the front keeps filling the queue.
`include "video_frame_packetizer_macros.svh"

module video_frame_packetizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,     // header type byte
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,       // data_byte[7:0], frame_size[39:8], timestamp_ms[71:40]
	input  logic        s_tuser,       // frame_first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,       // out_byte
	output logic        m_tlast,       // packet_end
	output logic [1:0]  m_tuser        // frame_end[0], run_last[1]
);

	vfp_pkg::entry_t      push_entry;
	vfp_pkg::entry_t      head;
	vfp_pkg::queue_stat_t q_stat;
	logic                 push;
	logic                 pop;
	logic                 frame_end;
	logic                 run_last;

	vfp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.data_byte    (s_tdata[7:0]),
		.frame_first  (s_tuser),
		.frame_size   (s_tdata[39:8]),
		.timestamp_ms (s_tdata[71:40]),
		.q_stat       (q_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	vfp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	vfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.packet_end (m_tlast),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

	assign m_tuser = {run_last, frame_end};

	// Front end never pushes into a full queue
	`VFP_ASSERT_IMPLIES(a_no_overflow, push, !q_stat.full, "push into full queue")
	// Header bytes never close a packet or a frame
	`VFP_ASSERT_IMPLIES(a_hdr_open, m_tvalid && !run_last, !m_tlast && !frame_end, "header byte marked as end")
	// Frame end always closes the packet
	`VFP_ASSERT_IMPLIES(a_fend_pend, m_tvalid && frame_end, m_tlast, "frame end without packet end")
	// A popped entry is shown on the output the cycle after the pop
	`VFP_ASSERT_NEXT(a_load, pop, m_tvalid, "popped entry not shown")

endmodule

>>> hdl/vfp_front.sv
module vfp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      data_byte,
	input  logic            frame_first,
	input  logic [31:0]     frame_size,
	input  logic [31:0]     timestamp_ms,
	input  vfp_pkg::queue_stat_t q_stat,
	output logic            push,
	output vfp_pkg::entry_t push_entry
);

	logic [7:0]                   type_byte_q;
	logic [31:0]                  frame_counter_q;
	logic [31:0]                  bytes_remaining_q;
	logic [vfp_pkg::FILL_W-1:0]   packet_fill_q;

	logic                         accept;
	logic [31:0]                  cnt_next;
	logic [31:0]                  rem_base;
	logic [31:0]                  rem_new;
	logic [vfp_pkg::FILL_W-1:0]   fill_base;
	logic [vfp_pkg::FILL_W-1:0]   fill_new;
	logic                         emit;
	logic                         fend;
	logic                         pend;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Classify the item against the open frame
	always_comb begin
		cnt_next  = frame_counter_q + 32'd1;
		rem_base  = frame_first ? frame_size : bytes_remaining_q;
		fill_base = frame_first ? vfp_pkg::FILL_W'(vfp_pkg::HEADER_BYTES) : packet_fill_q;
		emit      = (rem_base != 32'd0);
		rem_new   = rem_base - 32'd1;
		fill_new  = fill_base + vfp_pkg::FILL_W'(1);
		fend      = (rem_base == 32'd1);
		pend      = fend || (fill_new >= vfp_pkg::FILL_W'(vfp_pkg::PACKET_BYTES));
	end

	// Build the queue entry
	always_comb begin
		push_entry.hdr       = frame_first;
		push_entry.data_byte = data_byte;
		push_entry.pend      = pend;
		push_entry.fend      = fend;
		push_entry.fsize     = frame_size;
		push_entry.stamp     = timestamp_ms;
		push_entry.fcount    = cnt_next;
		push_entry.ftype     = type_byte_q;
	end

	assign push = accept && emit;

	// Hold the type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_byte_q <= 8'h00;
		end else if (cfg_we) begin
			type_byte_q <= cfg_wdata;
		end
	end

	// Advance frame state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q   <= 32'd0;
			bytes_remaining_q <= 32'd0;
			packet_fill_q     <= '0;
		end else if (accept) begin
			if (frame_first) begin
				frame_counter_q <= cnt_next;
			end
			if (emit) begin
				bytes_remaining_q <= rem_new;
				packet_fill_q     <= pend ? '0 : fill_new;
			end else if (frame_first) begin
				bytes_remaining_q <= 32'd0;
				packet_fill_q     <= '0;
			end
		end
	end

endmodule

>>> hdl/vfp_queue.sv
module vfp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vfp_pkg::entry_t       push_entry,
	input  logic                  pop,
	output vfp_pkg::entry_t       head,
	output vfp_pkg::queue_stat_t  stat
);

	localparam int unsigned CNT_W = $clog2(vfp_pkg::QUEUE_DEPTH + 1);

	vfp_pkg::entry_t                slots_q [vfp_pkg::QUEUE_DEPTH];
	logic [vfp_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [vfp_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]               count_q;
	logic                           do_push;
	logic                           do_pop;

	assign stat.full  = (count_q == CNT_W'(vfp_pkg::QUEUE_DEPTH));
	assign stat.valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && stat.valid;

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + vfp_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + vfp_pkg::QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/vfp_back.sv
module vfp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vfp_pkg::entry_t       head,
	input  vfp_pkg::queue_stat_t  q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_byte,
	output logic                  packet_end,
	output logic                  frame_end,
	output logic                  run_last
);

	vfp_pkg::entry_t               cur_q;
	logic                          valid_q;
	logic [vfp_pkg::IDX_W-1:0]     idx_q;
	logic                          at_payload;
	logic                          done;

	assign at_payload = (idx_q == vfp_pkg::PAYLOAD_IDX);
	assign done       = valid_q && out_ready && at_payload;
	assign pop        = q_stat.valid && (!valid_q || done);

	// Drive the current byte
	assign out_valid  = valid_q;
	assign out_byte   = at_payload ? cur_q.data_byte : vfp_pkg::hdr_byte(cur_q, idx_q);
	assign packet_end = at_payload && cur_q.pend;
	assign frame_end  = at_payload && cur_q.fend;
	assign run_last   = at_payload;

	// Hold the entry in flight
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Step through header bytes, load the next entry after the payload byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= vfp_pkg::PAYLOAD_IDX;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= head.hdr ? '0 : vfp_pkg::PAYLOAD_IDX;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (valid_q && out_ready) begin
			idx_q <= idx_q + vfp_pkg::IDX_W'(1);
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int STALL_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 64;
	localparam int RANDOM_ITEMS  = 225;
	localparam int REPORT_MAX    = 10;

	// One byte of the packet stream as the block should deliver it
	typedef struct packed {
		logic [7:0] data;
		logic       pend;
		logic       fend;
		logic       rlast;
	} pkt_byte_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	// Packetizer state as seen from outside
	logic [31:0] frame_count  = '0;
	logic [31:0] bytes_left   = '0;
	logic [16:0] packet_fill  = '0;
	logic [7:0]  hdr_type     = '0;
	pkt_byte_t   expected_bytes[$];

	bit no_idle = 1'b0;
	int items_sent;
	int items_dropped;
	int items_emitting;
	int frames_opened;
	int packet_splits;
	int bytes_checked;
	int type_writes;
	int mismatches;

	video_frame_packetizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the output side at random unless idling is off
	always @(posedge clk) begin
		m_tready <= no_idle || ($urandom_range(99) >= 23);
	end

	// Work out the packet bytes that one accepted item causes
	function automatic void packetize_item(logic [7:0] data, logic first,
			logic [31:0] fsize, logic [31:0] stamp);
		logic [8*vfp_pkg::HEADER_BYTES-1:0] header;
		logic                               pend;
		logic                               fend;
		if (first) begin
			frame_count = frame_count + 32'd1;
			bytes_left  = fsize;
			packet_fill = '0;
			if (fsize == 32'd0) begin
				items_dropped++;
				return;
			end
			frames_opened++;
			header = {vfp_pkg::START_CODE, fsize, stamp, frame_count, hdr_type};
			for (int i = vfp_pkg::HEADER_BYTES - 1; i >= 0; i--) begin
				expected_bytes.push_back('{header[8*i +: 8], 1'b0, 1'b0, 1'b0});
			end
			packet_fill = 17'(vfp_pkg::HEADER_BYTES);
		end else if (bytes_left == 32'd0) begin
			items_dropped++;
			return;
		end
		bytes_left  = bytes_left - 32'd1;
		packet_fill = packet_fill + 17'd1;
		fend = (bytes_left == 32'd0);
		pend = fend || (packet_fill >= 17'(vfp_pkg::PACKET_BYTES));
		if (pend) begin
			packet_fill = '0;
		end
		if (pend && !fend) begin
			packet_splits++;
		end
		expected_bytes.push_back('{data, pend, fend, 1'b1});
		items_emitting++;
	endfunction

	// Compare every accepted output byte with the oldest expectation
	always @(negedge clk) begin
		pkt_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			bytes_checked++;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("unexpected byte at %0t: %02h last %0b user %02b",
						$time, m_tdata, m_tlast, m_tuser);
				end
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data || m_tlast !== want.pend ||
						m_tuser[0] !== want.fend || m_tuser[1] !== want.rlast) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("mismatch at %0t: expected %02h pend %0b fend %0b rlast %0b,",
							$time, want.data, want.pend, want.fend, want.rlast);
						$display("    got %02h pend %0b fend %0b rlast %0b",
							m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
					end
				end
			end
		end
	end

	// End the run when neither side has moved an item for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb NOT OK");
		$finish;
	end

	// Offer one item, with random idle cycles ahead of it, and predict on acceptance
	task automatic send_item(input logic [7:0] data, input logic first,
			input logic [31:0] fsize, input logic [31:0] stamp);
		bit took;
		while (!no_idle && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stamp, fsize, data};
		s_tuser  <= first;
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		packetize_item(data, first, fsize, stamp);
		items_sent++;
	endtask

	// Hold the input side until every expected byte is out, then let the block settle
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_hdr_type(input logic [7:0] value);
		drain_outputs();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		hdr_type  = value;
		type_writes++;
	endtask

	// Open a frame and send count items of it; continuation items carry random side fields
	task automatic send_frame(input logic [31:0] fsize, input int count);
		send_item(8'($urandom), 1'b1, fsize, $urandom);
		for (int n = 1; n < count; n++) begin
			send_item(8'($urandom), 1'b0, $urandom, $urandom);
		end
	endtask

	function automatic logic [31:0] pick_frame_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 2) begin
			return 32'd0;
		end else if (roll < 70) begin
			return $urandom_range(1, 8);
		end
		return $urandom_range(9, 40);
	endfunction

	// Field extremes, dropped bytes, empty frame and an abandoned frame
	task automatic test_header_and_edges();
		send_item(8'h5A, 1'b0, 32'h0000_0005, 32'h0);
		send_item(8'h11, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(8'h22, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(8'h00, 1'b1, 32'h0000_0001, 32'h0000_0000);
		send_item(8'hFF, 1'b1, 32'h0000_0003, 32'hFFFF_FFFF);
		send_item(8'h00, 1'b0, 32'h0000_0000, 32'h0000_0000);
		send_item(8'hFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(8'h80, 1'b1, 32'hFFFF_FFFF, 32'h1234_5678);
		send_item(8'h01, 1'b0, 32'h0, 32'h0);
		send_item(8'hFE, 1'b0, 32'h0, 32'h0);
		send_item(8'h7F, 1'b1, 32'h0000_0002, 32'h8000_0000);
		send_item(8'hA5, 1'b0, 32'h0, 32'h0);
		send_item(8'h3C, 1'b0, 32'h0, 32'h0);
		drain_outputs();
	endtask

	// Type byte in the header across its range
	task automatic test_hdr_type();
		logic [7:0] values[5];
		values = '{8'hFF, 8'h80, 8'h01, 8'($urandom), 8'h00};
		foreach (values[i]) begin
			write_hdr_type(values[i]);
			send_frame(32'd2, 2);
		end
		drain_outputs();
	endtask

	// Frames back to back with no idling on either side, the queue runs full behind headers
	task automatic test_back_to_back();
		no_idle = 1'b1;
		send_frame(32'd40, 40);
		send_frame(32'd1, 1);
		send_frame(32'd3, 3);
		send_frame(32'd20, 20);
		send_frame(32'd6, 4);
		send_frame(32'd2, 2);
		drain_outputs();
		no_idle = 1'b0;
	endtask

	// Mostly whole frames, some cut short or overrun, some huge and abandoned, some noise
	task automatic test_random_streams();
		int          goal;
		int          seq;
		int          kind;
		int          roll;
		int          count;
		logic [31:0] fsize;
		goal = items_sent + RANDOM_ITEMS;
		seq  = 0;
		while (items_sent < goal) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				fsize = pick_frame_size();
				count = (fsize == 32'd0) ? 1 : int'(fsize);
				roll  = $urandom_range(9);
				if (roll == 0) begin
					count = $urandom_range(1, count);
				end else if (roll == 1) begin
					count += $urandom_range(1, 3);
				end
				send_frame(fsize, count);
			end else if (kind < 80) begin
				fsize = $urandom;
				if (fsize < 32'd64) begin
					fsize += 32'd64;
				end
				send_frame(fsize, $urandom_range(1, 5));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_item(8'($urandom), ($urandom_range(3) == 0),
						$urandom_range(0, 6), $urandom);
				end
			end
			seq++;
			if (seq % 25 == 12) begin
				drain_outputs();
			end
			if (seq % 40 == 39) begin
				write_hdr_type(8'($urandom));
			end
		end
		drain_outputs();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_and_edges();
		test_hdr_type();
		test_back_to_back();
		test_random_streams();
		drain_outputs();
		$display("covered %0d input items (%0d dropped, %0d with output), %0d frames opened",
			items_sent, items_dropped, items_emitting, frames_opened);
		$display("%0d bytes checked, packet splits inside a frame: %0d, type writes: %0d, mismatches: %0d",
			bytes_checked, packet_splits, type_writes, mismatches);
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/vfp_pkg.sv
hdl/vfp_front.sv
hdl/vfp_queue.sv
hdl/vfp_back.sv
hdl/video_frame_packetizer.sv
verif/tb.sv
